[design/fola_pkg.sv]
// ----------------------------------------------------------------------------
// fola_pkg
// Shared widths, command, status and register codes for the free-list
// allocator.
// ----------------------------------------------------------------------------
package fola_pkg;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 64;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 13;
  localparam int SHIFT_W  = 5;
  localparam int DATA_W   = 64;
  localparam int PADDR_W  = 5;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [SHIFT_W-1:0]  shift_t;

  // commands
  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_FREE  = 2'd1;
  localparam cmd_t CMD_INIT  = 2'd2;

  // result status
  localparam status_t STS_OK     = 2'd0;
  localparam status_t STS_EMPTY  = 2'd1;
  localparam status_t STS_REJECT = 2'd2;

  // register indexes (paddr[4:3])
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SHIFT = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  // object size limits, log2 bytes
  localparam shift_t SHIFT_MIN   = 5'd3;
  localparam shift_t SHIFT_MAX   = 5'd20;
  localparam shift_t SHIFT_RESET = 5'd12;

endpackage

[design/fola_in_if.sv]
// ----------------------------------------------------------------------------
// fola_in_if
// Command channel: valid/ready with command code and address.
// ----------------------------------------------------------------------------
interface fola_in_if;
  import fola_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  addr_t address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink   (input valid, input cmd, input address, output ready);

endinterface

[design/fola_out_if.sv]
// ----------------------------------------------------------------------------
// fola_out_if
// Result channel: valid/ready with status, object address and free count.
// ----------------------------------------------------------------------------
interface fola_out_if;
  import fola_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  addr_t   object_address;
  count_t  free_count;

  modport source (output valid, output status, output object_address,
                  output free_count, input ready);
  modport sink   (input valid, input status, input object_address,
                  input free_count, output ready);

endinterface

[design/fola_ram.sv]
// ----------------------------------------------------------------------------
// fola_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fola_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/fixed_object_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// fixed_object_free_list_allocator_core
// LIFO free-list allocator over a region of equal, power-of-two sized slots.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        cmd, address
//  out_ch   out  valid/ready        status, object_address, free_count
//  cfg_*    in   APB write/read     region_base, object_shift, slot_count
//
//  Steps: alloc, free: accept, two adder/shifter and link RAM steps, result
//  load (an empty alloc skips the second step; unknown cmd and empty init
//  skip both); init: one link RAM write per slot, through its single port.
//  Reset: sync, active low; head null, count zero, link RAM left uncleared.
//  Stalls: a done item waits in the output register while the next command
//  runs, which then holds in its last step until that register frees.
//
module fixed_object_free_list_allocator_core #(
  parameter int MAX_SLOTS = 4096
) (
  input  logic                    clk,
  input  logic                    rst_n,
  fola_in_if.sink                 in_ch,
  fola_out_if.source              out_ch,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [fola_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [fola_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [fola_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                    cfg_pready
);
  import fola_pkg::*;

  // slot index and slot/count widths; a slot value of MAX_SLOTS is null
  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int SLOT_W = IDX_W + 1;
  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(MAX_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ALLOC1, S_ALLOC2, S_FREE1, S_FREE2, S_RESP
  } state_t;

  // configuration
  addr_t  base_r, base_nxt;
  shift_t shift_r, shift_nxt;
  count_t scount_r, scount_nxt;

  // control and list state
  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;

  // item payload and working operand
  cmd_t    cmd_r, cmd_nxt;
  addr_t   addr_r, addr_nxt;
  addr_t   opnd_r, opnd_nxt;
  status_t res_status_r, res_status_nxt;
  addr_t   res_addr_r, res_addr_nxt;

  // output register
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  addr_t   out_addr_r, out_addr_nxt;
  count_t  out_count_r, out_count_nxt;

  // link RAM port
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  // shared adder/shifter
  addr_t  alu_a, alu_b, alu_sum;
  logic   alu_sub;
  shift_t sh;
  logic [SLOT_W-1:0] n_eff;

  logic   cfg_wr;
  addr_t  low_mask;
  addr_t  slot64;
  logic   free_bad;
  logic [SLOT_W-1:0] idx_inc;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[4:3])
      REG_BASE:  cfg_prdata = base_r;
      REG_SHIFT: cfg_prdata = DATA_W'(shift_r);
      REG_COUNT: cfg_prdata = DATA_W'(scount_r);
      default:   cfg_prdata = '0;
    endcase
  end

  always_comb begin
    base_nxt   = base_r;
    shift_nxt  = shift_r;
    scount_nxt = scount_r;
    if (cfg_wr) begin
      case (cfg_paddr[4:3])
        REG_BASE:  base_nxt   = cfg_pwdata;
        REG_SHIFT: shift_nxt  = cfg_pwdata[SHIFT_W-1:0];
        REG_COUNT: scount_nxt = cfg_pwdata[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // effective shift (clamped) and slot count (limited to MAX_SLOTS)
  always_comb begin
    if (shift_r < SHIFT_MIN)      sh = SHIFT_MIN;
    else if (shift_r > SHIFT_MAX) sh = SHIFT_MAX;
    else                          sh = shift_r;
  end

  assign n_eff = (32'(scount_r) > 32'(MAX_SLOTS)) ? NULL_SLOT : SLOT_W'(scount_r);

  // ---------------------------------------------------------- shared unit
  assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  // free checks work on the registered offset
  assign low_mask = ~({ADDR_W{1'b1}} << sh);
  assign slot64   = opnd_r >> sh;
  assign free_bad = (addr_r == '0) || ((opnd_r & low_mask) != '0) ||
                    (slot64 >= ADDR_W'(n_eff));

  assign idx_inc  = SLOT_W'(idx_r) + SLOT_W'(1);

  fola_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------------ sequencer
  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    total_nxt      = total_r;
    idx_nxt        = idx_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    opnd_nxt       = opnd_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_count_nxt  = out_count_r;

    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = NULL_SLOT;
    ram_raddr = head_r[IDX_W-1:0];

    alu_a   = base_r;
    alu_b   = opnd_r;
    alu_sub = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt  = in_ch.cmd;
          addr_nxt = in_ch.address;
          idx_nxt  = '0;
          res_addr_nxt = '0;
          case (in_ch.cmd)
            CMD_ALLOC: state_nxt = S_ALLOC1;
            CMD_FREE:  state_nxt = S_FREE1;
            CMD_INIT: begin
              if (n_eff == '0) begin
                // empty region: nothing to link
                head_nxt       = NULL_SLOT;
                total_nxt      = '0;
                res_status_nxt = STS_OK;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_INIT;
              end
            end
            default: begin
              res_status_nxt = STS_REJECT;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end

      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = (idx_inc < n_eff) ? idx_inc : NULL_SLOT;
        if (idx_inc == n_eff) begin
          head_nxt       = '0;
          total_nxt      = n_eff;
          res_status_nxt = STS_OK;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt = idx_inc[IDX_W-1:0];
        end
      end

      S_ALLOC1: begin
        // link read of head issued here; head scaled into the operand
        if (total_r == '0 || head_r >= NULL_SLOT) begin
          res_status_nxt = STS_EMPTY;
          state_nxt      = S_RESP;
        end else begin
          opnd_nxt  = ADDR_W'(head_r[IDX_W-1:0]) << sh;
          state_nxt = S_ALLOC2;
        end
      end

      S_ALLOC2: begin
        alu_a          = base_r;
        alu_b          = opnd_r;
        res_addr_nxt   = alu_sum;
        res_status_nxt = STS_OK;
        head_nxt       = ram_rdata;
        total_nxt      = total_r - SLOT_W'(1);
        state_nxt      = S_RESP;
      end

      S_FREE1: begin
        alu_a     = addr_r;
        alu_b     = base_r;
        alu_sub   = 1'b1;
        opnd_nxt  = alu_sum;
        state_nxt = S_FREE2;
      end

      S_FREE2: begin
        if (free_bad) begin
          res_status_nxt = STS_REJECT;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = slot64[IDX_W-1:0];
          ram_wdata      = head_r;
          head_nxt       = {1'b0, slot64[IDX_W-1:0]};
          if (total_r < n_eff) total_nxt = total_r + SLOT_W'(1);
          res_status_nxt = STS_OK;
          res_addr_nxt   = addr_r;
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_addr_nxt   = res_addr_r;
          out_count_nxt  = COUNT_W'(total_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      shift_r     <= SHIFT_RESET;
      scount_r    <= COUNT_W'(4096);
      head_r      <= NULL_SLOT;
      total_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      shift_r     <= shift_nxt;
      scount_r    <= scount_nxt;
      head_r      <= head_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    opnd_r       <= opnd_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.object_address = out_addr_r;
  assign out_ch.free_count     = out_count_r;

  // ----------------------------------------------------------- assertions
  // count never passes the slot limit
  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= NULL_SLOT)
    else $error("free count above slot limit");

  // an accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start");

  // a successful pop takes exactly one from the count
  a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC2) |=> (total_r == $past(total_r) - SLOT_W'(1)))
    else $error("alloc did not decrement count");

  // links are written only while building the list or pushing a slot
  a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_INIT || state_r == S_FREE2))
    else $error("link write outside init or free");

  // a pending result is never overwritten before it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_addr_r)))
    else $error("pending result lost");

  // a free step is only ever entered for a free command
  a_cmd_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FREE1) |-> (cmd_r == CMD_FREE))
    else $error("free step without free command");

endmodule
